// ===== sv/dplc_pkg.sv =====
// Shared types and constants for the dual PID lift controller.
// No dependencies; imported by dplc_side and dual_pid_lift_controller_core.
package dplc_pkg;

    // Saturation bound of each drive output.
    localparam int DRIVE_MAX = 127;

    // Register indexes of the configuration port (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_TARGET     = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_ZONE       = 3'd4,
        REG_SUM_LIMIT  = 3'd5,
        REG_LEFT_TOL   = 3'd6,
        REG_RIGHT_TOL  = 3'd7
    } t_reg_idx;

    // Register reset values.
    localparam logic [10:0] TARGET_RST    = 11'd900;
    localparam logic [23:0] GAIN_P_RST    = 24'd78643;
    localparam logic [23:0] GAIN_I_RST    = 24'd459;
    localparam logic [23:0] GAIN_D_RST    = 24'd2621;
    localparam logic [11:0] ZONE_RST      = 12'd200;
    localparam logic [22:0] SUM_LIMIT_RST = 23'd7143;
    localparam logic [10:0] LEFT_TOL_RST  = 11'd10;
    localparam logic [10:0] RIGHT_TOL_RST = 11'd0;

    // Pipeline advance strobes handed from the top level to each side.
    typedef struct packed {
        logic adv1;   // request leaves the input register
        logic adv2;   // request leaves the product register
    } t_pipe_ctl;

endpackage

// ===== sv/dplc_side.sv =====
// One side of the lift controller: error, state update, PID products,
// saturation and drive register. Depends on dplc_pkg.
module dplc_side
    import dplc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SUM_BITS       = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_pipe_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [10:0]            i_target,
    input  logic [23:0]            i_gain_p,
    input  logic [23:0]            i_gain_i,
    input  logic [23:0]            i_gain_d,
    input  logic [11:0]            i_zone,
    input  logic [22:0]            i_sum_limit,
    input  logic [10:0]            i_tol,
    output logic signed [7:0]      o_drive
);

    localparam int HALF_W = SAMPLE_BITS - 1;
    localparam int EW     = ((HALF_W > 11) ? HALF_W : 11) + 1;
    localparam int CW0    = (SUM_BITS > EW) ? SUM_BITS : EW;
    localparam int CW     = ((CW0 > 23) ? CW0 : 23) + 2;
    localparam int MW     = EW + 11;
    localparam int PPW    = EW + 25;
    localparam int IPW    = SUM_BITS + 25;
    localparam int DPW    = EW + 26;
    localparam int TW0    = (IPW > DPW) ? IPW : DPW;
    localparam int TW     = TW0 + 2;

    localparam logic signed [CW-1:0] SUM_MAX_C = CW'(2**(SUM_BITS-1) - 1);
    localparam logic signed [CW-1:0] SUM_MIN_C = ~SUM_MAX_C;
    localparam logic signed [TW-1:0] LIM_C     = TW'(DRIVE_MAX) <<< GAIN_FRAC_BITS;

    logic signed [SUM_BITS-1:0] r_sum, n_sum;
    logic signed [EW-1:0]       r_prev;
    logic signed [PPW-1:0]      r_pp;
    logic signed [IPW-1:0]      r_ip;
    logic signed [DPW-1:0]      r_dp;
    logic                       r_dead;
    logic signed [7:0]          r_drive, n_drive;

    logic [HALF_W-1:0]     half;
    logic signed [EW-1:0]  err;
    logic signed [EW:0]    diff;
    logic [EW-1:0]         err_mag;
    logic                  dead;
    logic signed [PPW-1:0] pp;
    logic signed [IPW-1:0] ip;
    logic signed [DPW-1:0] dp;
    logic signed [CW-1:0]  acc, clamped;
    logic signed [TW-1:0]  total, sat;
    logic [TW-1:0]         tot_mag;
    logic [7:0]            whole;

    // Stage 1: error, products against the sum from before this request.
    assign half    = i_sample[SAMPLE_BITS-1:1];
    assign err     = EW'({1'b0, i_target}) - EW'(half);
    assign diff    = (EW+1)'(err) - (EW+1)'(r_prev);
    assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
    assign dead    = (MW'(err_mag) <= MW'(i_tol));

    assign pp = PPW'(err)   * PPW'($signed({1'b0, i_gain_p}));
    assign ip = IPW'(r_sum) * IPW'($signed({1'b0, i_gain_i}));
    assign dp = DPW'(diff)  * DPW'($signed({1'b0, i_gain_d}));

    always_comb begin
        if (CW'(err) < CW'($signed({1'b0, i_zone}))) begin
            acc = CW'(r_sum) + CW'(err);
        end else begin
            acc = '0;
        end
        clamped = acc;
        if (clamped > CW'($signed({1'b0, i_sum_limit}))) begin
            clamped = CW'($signed({1'b0, i_sum_limit}));
        end
        if (clamped > SUM_MAX_C) begin
            clamped = SUM_MAX_C;
        end
        if (clamped < SUM_MIN_C) begin
            clamped = SUM_MIN_C;
        end
        n_sum = clamped[SUM_BITS-1:0];
    end

    // Stage 2: add the terms, saturate, truncate toward zero, negate; zero inside the tolerance.
    assign total = TW'(r_pp) + TW'(r_ip) + TW'(r_dp);

    always_comb begin
        sat = total;
        if (total > LIM_C) begin
            sat = LIM_C;
        end else if (total < -LIM_C) begin
            sat = -LIM_C;
        end
        tot_mag = sat[TW-1] ? TW'(-sat) : TW'(sat);
        whole   = {1'b0, tot_mag[GAIN_FRAC_BITS +: 7]};
        if (r_dead) begin
            n_drive = '0;
        end else if (sat[TW-1]) begin
            n_drive = $signed(whole);
        end else begin
            n_drive = -$signed(whole);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_ctl.adv1) begin
            r_sum  <= n_sum;
            r_prev <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_pp   <= pp;
            r_ip   <= ip;
            r_dp   <= dp;
            r_dead <= dead;
        end
        if (i_ctl.adv2) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

// ===== sv/dual_pid_lift_controller_core.sv =====
// Dual PID lift controller top level: APB register file, request pipeline
// control and two dplc_side instances. Depends on dplc_pkg and dplc_side.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one pair of raw potentiometer
//   samples per request. A request is taken at a clock edge with i_valid high
//   and o_stall low. Output channel (o_valid / i_stall) returns one pair of
//   drive commands per request, in order, taken when o_valid is high and
//   i_stall is low.
//   o_valid rises once the request has passed the input register, product
//   register and drive register. Throughput: one request per cycle while the
//   receiver does not stall; the error sum and previous error update as each
//   request leaves stage 1, so back-to-back requests never wait on each other.
//   When the receiver stalls, the drive register holds and each stage keeps
//   accepting until its successor is full; o_stall rises only when all three
//   stages are occupied and the receiver stalls.
//   Reset (i_rst_n low, synchronous) empties the pipeline, zeroes both error
//   sums and previous errors, and loads the register defaults.
//   Registers are written over APB at byte address 4 * index; write them only
//   while the pipeline is empty.
module dual_pid_lift_controller_core
    import dplc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 12,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SUM_BITS       = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    // output channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [7:0]      o_left_drive,
    output logic signed [7:0]      o_right_drive,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Configuration registers.
    logic [10:0] r_target;
    logic [23:0] r_gain_p;
    logic [23:0] r_gain_i;
    logic [23:0] r_gain_d;
    logic [11:0] r_zone;
    logic [22:0] r_sum_limit;
    logic [10:0] r_left_tol;
    logic [10:0] r_right_tol;

    // Pipeline occupancy and the input register.
    logic                   r_v1, r_v2, r_out_v;
    logic [SAMPLE_BITS-1:0] r_left_sample, r_right_sample;

    logic      out_free, s2_free, s1_free, accept;
    t_pipe_ctl ctl;
    t_reg_idx  reg_idx;
    logic      cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes: the low address bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_RST;
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_zone      <= ZONE_RST;
            r_sum_limit <= SUM_LIMIT_RST;
            r_left_tol  <= LEFT_TOL_RST;
            r_right_tol <= RIGHT_TOL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TARGET:    r_target    <= pwdata[10:0];
                REG_GAIN_P:    r_gain_p    <= pwdata[23:0];
                REG_GAIN_I:    r_gain_i    <= pwdata[23:0];
                REG_GAIN_D:    r_gain_d    <= pwdata[23:0];
                REG_ZONE:      r_zone      <= pwdata[11:0];
                REG_SUM_LIMIT: r_sum_limit <= pwdata[22:0];
                REG_LEFT_TOL:  r_left_tol  <= pwdata[10:0];
                REG_RIGHT_TOL: r_right_tol <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (reg_idx)
            REG_TARGET:    prdata = 32'(r_target);
            REG_GAIN_P:    prdata = 32'(r_gain_p);
            REG_GAIN_I:    prdata = 32'(r_gain_i);
            REG_GAIN_D:    prdata = 32'(r_gain_d);
            REG_ZONE:      prdata = 32'(r_zone);
            REG_SUM_LIMIT: prdata = 32'(r_sum_limit);
            REG_LEFT_TOL:  prdata = 32'(r_left_tol);
            REG_RIGHT_TOL: prdata = 32'(r_right_tol);
            default:       prdata = '0;
        endcase
    end

    // Flow control: a stage advances when the one after it is empty or
    // moving on in the same cycle.
    assign out_free = !r_out_v || !i_stall;
    assign ctl.adv2 = r_v2 && out_free;
    assign s2_free  = !r_v2 || out_free;
    assign ctl.adv1 = r_v1 && s2_free;
    assign s1_free  = !r_v1 || s2_free;
    assign o_stall  = !s1_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_out_v <= r_v2;
            end
        end
    end

    // Input register: hold the samples until stage 1 consumes them.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_sample  <= i_left_sample;
            r_right_sample <= i_right_sample;
        end
    end

    dplc_side #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (r_left_sample),
        .i_target    (r_target),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_zone      (r_zone),
        .i_sum_limit (r_sum_limit),
        .i_tol       (r_left_tol),
        .o_drive     (o_left_drive)
    );

    dplc_side #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (r_right_sample),
        .i_target    (r_target),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_zone      (r_zone),
        .i_sum_limit (r_sum_limit),
        .i_tol       (r_right_tol),
        .o_drive     (o_right_drive)
    );

    assign o_valid = r_out_v;

endmodule
